// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the band energy ratio meter RTL.
// Self-contained; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked at every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- hw/rtl/ber_pkg.sv -----
// Package of the band energy ratio meter: widths, reset values, payload
// structs and state encodings. No dependencies.
package ber_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int COEF_BITS       = 16;
    localparam int WIN_BITS        = 16;
    localparam int ENERGY_BITS     = 64;
    localparam int RATIO_BITS      = 24;
    localparam int RATIO_FRAC_BITS = 16;

    // Filter datapath.
    localparam int FILT_W = SAMPLE_BITS;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int STEP_W = SAMPLE_BITS + 2;
    localparam int MUL_W  = (DIFF_W > COEF_BITS + 1) ? DIFF_W : COEF_BITS + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_BITS - 1);

    // Ratio datapath: the quotient carries twice the fraction bits of the root.
    localparam int QUO_BITS      = 2 * RATIO_BITS;
    localparam int FRAC_SHIFT    = 2 * RATIO_FRAC_BITS;
    localparam int SAT_SHIFT     = QUO_BITS - FRAC_SHIFT;
    localparam int DIV_STEP_BITS = $clog2(QUO_BITS);
    localparam logic [QUO_BITS-1:0]   ROOT_TOP_BIT = QUO_BITS'(1) << (QUO_BITS - 2);
    localparam logic [RATIO_BITS-1:0] RATIO_SAT    = {RATIO_BITS{1'b1}};

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Register port.
    localparam int REG_IDX_BITS  = 2;
    localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;
    localparam int APB_DATA_BITS = 32;

    localparam logic [WIN_BITS-1:0]  WINDOW_RESET = WIN_BITS'(4800);
    localparam logic [COEF_BITS-1:0] SLOW_RESET   = COEF_BITS'(852);
    localparam logic [COEF_BITS-1:0] FAST_RESET   = COEF_BITS'(3345);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_WINDOW = 2'd0,
        REG_SLOW   = 2'd1,
        REG_FAST   = 2'd2
    } t_ber_reg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } t_ber_in;

    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic                  boom_silent;
    } t_ber_out;

    typedef struct packed {
        logic [WIN_BITS-1:0]  window_length;
        logic [COEF_BITS-1:0] slow_coef;
        logic [COEF_BITS-1:0] fast_coef;
    } t_ber_cfg;

    typedef struct packed {
        logic [ENERGY_BITS-1:0] thump;
        logic [ENERGY_BITS-1:0] boom;
    } t_ber_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SLOW,
        F_FAST,
        F_BOOM,
        F_THUMP
    } t_ber_front_state;

    typedef enum logic [2:0] {
        R_IDLE,
        R_CHECK,
        R_DIV,
        R_SQRT,
        R_DONE
    } t_ber_ratio_state;

endpackage

// ----- hw/rtl/ber_front.sv -----
// Front end of the band energy ratio meter: accepts samples, runs both
// one-pole filters and the energy sums on one shared multiplier.
// Depends on ber_pkg.
module ber_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ber_pkg::t_ber_cfg i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ber_pkg::t_ber_in  i_in_data,
    output logic             o_push,
    output ber_pkg::t_ber_job o_job,
    input  logic             i_full
);
    import ber_pkg::*;

    t_ber_front_state r_state, n_state;

    logic signed [FILT_W-1:0] r_x, n_x;
    logic signed [FILT_W-1:0] r_slow, n_slow;
    logic signed [FILT_W-1:0] r_fast, n_fast;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [ENERGY_BITS-1:0]   r_boom, n_boom;
    logic [ENERGY_BITS-1:0]   r_thump, n_thump;
    logic [WIN_BITS-1:0]      r_count, n_count;

    logic signed [FILT_W-1:0] slow_base;
    logic signed [DIFF_W-1:0] diff_in, diff_fast, diff_band;
    logic signed [MUL_W-1:0]  coef_slow, coef_fast;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] product, prod_rounded;
    logic signed [STEP_W-1:0] pole_step;
    logic signed [FILT_W-1:0] filt_base, filt_next;
    logic [ENERGY_BITS-1:0]   square, acc_base, acc_next;
    logic [ENERGY_BITS:0]     acc_sum;
    logic [WIN_BITS:0]        count_next, win_eff;
    logic                     window_done;

    // A restart clears the filters before this sample, so the first
    // product already sees a zero slow filter.
    assign slow_base = i_in_data.restart ? '0 : r_slow;
    assign diff_in   = DIFF_W'(i_in_data.sample) - DIFF_W'(slow_base);
    assign diff_fast = DIFF_W'(r_x) - DIFF_W'(r_fast);
    assign diff_band = DIFF_W'(r_fast) - DIFF_W'(r_slow);
    assign coef_slow = MUL_W'($signed({1'b0, i_cfg.slow_coef}));
    assign coef_fast = MUL_W'($signed({1'b0, i_cfg.fast_coef}));

    always_comb begin
        case (r_state)
            F_IDLE: begin
                mul_a = MUL_W'(diff_in);
                mul_b = coef_slow;
            end
            F_SLOW: begin
                mul_a = MUL_W'(diff_fast);
                mul_b = coef_fast;
            end
            F_FAST: begin
                mul_a = MUL_W'(r_slow);
                mul_b = MUL_W'(r_slow);
            end
            default: begin
                mul_a = MUL_W'(diff_band);
                mul_b = MUL_W'(diff_band);
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Rounding half up, then a floor shift: the filter never overshoots.
    assign prod_rounded = r_prod + ROUND_HALF;
    assign pole_step    = STEP_W'(prod_rounded >>> COEF_BITS);
    assign filt_base    = (r_state == F_FAST) ? r_fast : r_slow;
    assign filt_next    = FILT_W'(STEP_W'(filt_base) + pole_step);

    assign square   = ENERGY_BITS'($unsigned(r_prod));
    assign acc_base = (r_state == F_BOOM) ? r_boom : r_thump;
    assign acc_sum  = {1'b0, acc_base} + {1'b0, square};
    assign acc_next = acc_sum[ENERGY_BITS] ? '1 : acc_sum[ENERGY_BITS-1:0];

    assign count_next  = {1'b0, r_count} + (WIN_BITS + 1)'(1);
    assign win_eff     = (i_cfg.window_length == '0) ? (WIN_BITS + 1)'(1)
                                                     : {1'b0, i_cfg.window_length};
    assign window_done = count_next >= win_eff;

    assign o_job = '{thump: acc_next, boom: r_boom};

    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_slow     = r_slow;
        n_fast     = r_fast;
        n_prod     = r_prod;
        n_boom     = r_boom;
        n_thump    = r_thump;
        n_count    = r_count;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_x    = i_in_data.sample;
                    n_prod = product;
                    if (i_in_data.restart) begin
                        n_slow  = '0;
                        n_fast  = '0;
                        n_boom  = '0;
                        n_thump = '0;
                        n_count = '0;
                    end
                    n_state = F_SLOW;
                end
            end
            F_SLOW: begin
                n_slow  = filt_next;
                n_prod  = product;
                n_state = F_FAST;
            end
            F_FAST: begin
                n_fast  = filt_next;
                n_prod  = product;
                n_state = F_BOOM;
            end
            F_BOOM: begin
                n_boom  = acc_next;
                n_prod  = product;
                n_state = F_THUMP;
            end
            F_THUMP: begin
                if (!window_done) begin
                    n_thump = acc_next;
                    n_count = count_next[WIN_BITS-1:0];
                    n_state = F_IDLE;
                end else if (!i_full) begin
                    // Closing sample: hand both sums to the back end.
                    o_push  = 1'b1;
                    n_boom  = '0;
                    n_thump = '0;
                    n_count = '0;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow  <= '0;
            r_fast  <= '0;
            r_boom  <= '0;
            r_thump <= '0;
            r_count <= '0;
        end else begin
            r_slow  <= n_slow;
            r_fast  <= n_fast;
            r_boom  <= n_boom;
            r_thump <= n_thump;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_prod <= n_prod;
    end

endmodule

// ----- hw/rtl/ber_queue.sv -----
// Short queue of closed windows between front and back end.
// Depends on ber_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ber_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ber_pkg::t_ber_job i_job,
    output logic             o_full,
    input  logic             i_pop,
    output ber_pkg::t_ber_job o_job,
    output logic             o_empty
);
    import ber_pkg::*;

    localparam logic [QPTR_BITS:0] DEPTH_CNT = (QPTR_BITS + 1)'(QUEUE_DEPTH);

    t_ber_job               r_mem [QUEUE_DEPTH];
    t_ber_job               r_head;
    logic [QPTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QPTR_BITS:0]     r_count, n_count;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_head;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QPTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QPTR_BITS + 1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QPTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        // The head word is held in a register; a word pushed into the slot
        // that becomes the head goes straight through.
        if (i_push && (n_rd_ptr == r_wr_ptr)) begin
            r_head <= i_job;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into a full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from an empty queue")
    `ASSERT_RST(a_count_range, i_clk, i_rst_n, r_count <= DEPTH_CNT, "queue count out of range")

endmodule

// ----- hw/rtl/ber_ratio.sv -----
// Back end of the band energy ratio meter: bit-serial division of the
// thump sum by the boom sum, bit-pair square root, and the output register.
// Depends on ber_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ber_ratio (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  ber_pkg::t_ber_job i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ber_pkg::t_ber_out o_out_data
);
    import ber_pkg::*;

    localparam logic [DIV_STEP_BITS-1:0] DIV_LAST = DIV_STEP_BITS'(QUO_BITS - 1);

    t_ber_ratio_state r_state, n_state;

    logic [ENERGY_BITS-1:0]   r_num, n_num;
    logic [ENERGY_BITS-1:0]   r_den, n_den;
    logic [ENERGY_BITS-1:0]   r_rem, n_rem;
    logic [QUO_BITS-1:0]      r_quo, n_quo;
    logic [QUO_BITS-1:0]      r_root, n_root;
    logic [QUO_BITS-1:0]      r_bit, n_bit;
    logic [DIV_STEP_BITS-1:0] r_step, n_step;
    t_ber_out                 r_result, n_result;
    logic                     r_out_valid, n_out_valid;
    t_ber_out                 r_out;

    logic                     sat_check;
    logic [ENERGY_BITS:0]     div_trial, div_diff;
    logic                     div_ge;
    logic [QUO_BITS-1:0]      root_trial, root_next;
    logic                     root_ge;
    logic                     load_out;

    // The quotient only fits when thump is below boom times two to the
    // power of the integer bits of the root squared.
    assign sat_check = {{SAT_SHIFT{1'b0}}, r_num} >= {r_den, {SAT_SHIFT{1'b0}}};

    // Restoring division; r_quo shifts out dividend bits and takes in
    // quotient bits, and afterwards holds the radicand.
    assign div_trial = {r_rem, r_quo[QUO_BITS-1]};
    assign div_diff  = div_trial - {1'b0, r_den};
    assign div_ge    = div_trial >= {1'b0, r_den};

    assign root_trial = r_root + r_bit;
    assign root_ge    = r_quo >= root_trial;
    assign root_next  = root_ge ? (r_root >> 1) + r_bit : r_root >> 1;

    always_comb begin
        n_state  = r_state;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_root   = r_root;
        n_bit    = r_bit;
        n_step   = r_step;
        n_result = r_result;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            R_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_num   = i_job.thump;
                    n_den   = i_job.boom;
                    n_state = R_CHECK;
                end
            end
            R_CHECK: begin
                if (r_den == '0) begin
                    n_result = '{ratio: RATIO_SAT, boom_silent: 1'b1};
                    n_state  = R_DONE;
                end else if (sat_check) begin
                    n_result = '{ratio: RATIO_SAT, boom_silent: 1'b0};
                    n_state  = R_DONE;
                end else begin
                    n_rem   = r_num >> SAT_SHIFT;
                    n_quo   = {r_num[SAT_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
                    n_step  = '0;
                    n_state = R_DIV;
                end
            end
            R_DIV: begin
                n_rem  = div_ge ? div_diff[ENERGY_BITS-1:0] : div_trial[ENERGY_BITS-1:0];
                n_quo  = {r_quo[QUO_BITS-2:0], div_ge};
                n_step = r_step + DIV_STEP_BITS'(1);
                if (r_step == DIV_LAST) begin
                    n_root  = '0;
                    n_bit   = ROOT_TOP_BIT;
                    n_state = R_SQRT;
                end
            end
            R_SQRT: begin
                if (root_ge) begin
                    n_quo = r_quo - root_trial;
                end
                n_root = root_next;
                n_bit  = r_bit >> 2;
                if (r_bit[0]) begin
                    n_result = '{ratio: root_next[RATIO_BITS-1:0], boom_silent: 1'b0};
                    n_state  = R_DONE;
                end
            end
            R_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = R_IDLE;
                end
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_root   <= n_root;
        r_bit    <= n_bit;
        r_step   <= n_step;
        r_result <= n_result;
        if (load_out) begin
            r_out <= r_result;
        end
    end

    `ASSERT_RST(a_div_rem, i_clk, i_rst_n, (r_state == R_DIV) |-> (r_rem < r_den), "division remainder not below divisor")
    `ASSERT_RST(a_root_bit, i_clk, i_rst_n, (r_state == R_SQRT) |-> $onehot(r_bit), "root bit lost")
    `ASSERT_NEVER(a_pop_busy, i_clk, i_rst_n, o_pop && (r_state != R_IDLE), "job taken while busy")

endmodule

// ----- hw/rtl/band_energy_ratio_meter.sv -----
// Top level of the band energy ratio meter: register port, front end,
// window queue and ratio back end. Depends on ber_pkg and the ber_* modules.
//
//  channel   direction  handshake                 word
//  input     in         i_in_valid / o_in_ready   ber_pkg::t_ber_in (sample, restart)
//  output    out        o_out_valid / i_out_ready ber_pkg::t_ber_out (ratio, boom_silent)
//  register  in         psel, penable, pwrite     window, slow and fast coefficient
//
// In the front end a sample makes four passes through its one shared
// multiplier, then an accumulate step closes the sample.
// A closed window passes the back end in steps (take from the queue, check,
// 48 division steps, 24 root steps, hand-off); a saturated ratio skips to hand-off.
// Synchronous active-low reset loads the register reset values and clears
// filters, sums and count; there is no clearing pass.
// A full queue holds the front end on its closing sample; an unread output
// word holds the back end once its next result is ready.
module band_energy_ratio_meter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ber_pkg::t_ber_in                      i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ber_pkg::t_ber_out                     o_out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ber_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [ber_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [ber_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);
    import ber_pkg::*;

    t_ber_cfg r_cfg;
    t_ber_reg reg_idx;
    logic     reg_write;

    logic     push, full, pop, empty;
    t_ber_job push_job, pop_job;

    assign pready    = 1'b1;
    assign reg_idx   = t_ber_reg'(paddr[APB_ADDR_BITS-1:2]);
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{window_length: WINDOW_RESET, slow_coef: SLOW_RESET,
                       fast_coef: FAST_RESET};
        end else if (reg_write) begin
            case (reg_idx)
                REG_WINDOW: r_cfg.window_length <= pwdata[WIN_BITS-1:0];
                REG_SLOW:   r_cfg.slow_coef     <= pwdata[COEF_BITS-1:0];
                REG_FAST:   r_cfg.fast_coef     <= pwdata[COEF_BITS-1:0];
                default:    r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WINDOW: prdata = APB_DATA_BITS'(r_cfg.window_length);
            REG_SLOW:   prdata = APB_DATA_BITS'(r_cfg.slow_coef);
            REG_FAST:   prdata = APB_DATA_BITS'(r_cfg.fast_coef);
            default:    prdata = '0;
        endcase
    end

    ber_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    ber_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    ber_ratio u_ratio (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- verif/band_energy_ratio_meter_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard of the band energy ratio meter: watches the sample, result and
// register ports, predicts every ratio word and compares it. Depends on ber_pkg.
module band_energy_ratio_meter_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  ber_pkg::t_ber_in                  i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  ber_pkg::t_ber_out                 i_out_data,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [ber_pkg::APB_ADDR_BITS-1:0] i_paddr,
    input  logic [ber_pkg::APB_DATA_BITS-1:0] i_pwdata,
    input  logic [ber_pkg::APB_DATA_BITS-1:0] i_prdata,
    input  logic                              i_pready,
    output int                                o_fail_count,
    output int                                o_pending
);
    import ber_pkg::*;

    logic [WIN_BITS-1:0]  window_reg = WINDOW_RESET;
    logic [COEF_BITS-1:0] slow_reg   = SLOW_RESET;
    logic [COEF_BITS-1:0] fast_reg   = FAST_RESET;

    // The filters never leave the range spanned by the samples, so 64 bits
    // hold them with room to spare.
    longint          slow_lp;
    longint          fast_lp;
    longint unsigned boom_sum;
    longint unsigned thump_sum;
    logic [WIN_BITS-1:0] fill_count;

    t_ber_out pending_ratios[$];
    int       fails = 0;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic longint lowpass_step(longint f, longint x, logic [COEF_BITS-1:0] coef);
        longint prod;
        prod = (x - f) * longint'({1'b0, coef});
        // Arithmetic shift floors, which gives rounding half up after the bias.
        return f + ((prod + 32768) >>> 16);
    endfunction

    function automatic longint unsigned square_mag(longint v);
        longint unsigned m;
        if (v < 0)
            m = -v;
        else
            m = v;
        return m * m;
    endfunction

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [RATIO_BITS-1:0] amplitude_ratio(longint unsigned thump,
                                                              longint unsigned boom);
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        logic            carry;
        quo = thump / boom;
        rem = thump % boom;
        if (quo >= 64'h1_0000)
            return RATIO_SAT;
        // Extend the quotient by 32 fraction bits so that its root has 16.
        for (int i = 0; i < 32; i++) begin
            carry = rem[63];
            rem = rem << 1;
            quo = quo << 1;
            if (carry || rem >= boom) begin
                rem = rem - boom;
                quo[0] = 1'b1;
            end
        end
        root = 0;
        probe = 64'd1 << 46;
        while (probe > quo)
            probe = probe >> 2;
        while (probe != 0) begin
            if (quo >= root + probe) begin
                quo = quo - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return (root > 64'hFF_FFFF) ? RATIO_SAT : root[RATIO_BITS-1:0];
    endfunction

    task automatic clear_measurement();
        slow_lp = 0;
        fast_lp = 0;
        boom_sum = 0;
        thump_sum = 0;
        fill_count = '0;
    endtask

    task automatic measure_sample(input t_ber_in w, output bit emits, output t_ber_out word);
        longint      x;
        int unsigned span;
        int unsigned filled;
        x = longint'($signed(w.sample));
        if (w.restart)
            clear_measurement();
        slow_lp = lowpass_step(slow_lp, x, slow_reg);
        fast_lp = lowpass_step(fast_lp, x, fast_reg);
        boom_sum = sat_add(boom_sum, square_mag(slow_lp));
        thump_sum = sat_add(thump_sum, square_mag(fast_lp - slow_lp));
        span = (window_reg == 0) ? 1 : window_reg;
        filled = fill_count + 1;
        emits = (filled >= span);
        word = '0;
        if (!emits) begin
            fill_count = filled[WIN_BITS-1:0];
        end else begin
            // Only the sums and the count close with the window; the filters run on.
            if (boom_sum == 0) begin
                word.ratio = RATIO_SAT;
                word.boom_silent = 1'b1;
            end else begin
                word.ratio = amplitude_ratio(thump_sum, boom_sum);
                word.boom_silent = 1'b0;
            end
            boom_sum = 0;
            thump_sum = 0;
            fill_count = '0;
        end
    endtask

    initial clear_measurement();

    always @(posedge i_clk) begin
        t_ber_out             want;
        bit                   emits;
        t_ber_reg             reg_sel;
        logic [COEF_BITS-1:0] held;
        if (!i_rst_n) begin
            window_reg = WINDOW_RESET;
            slow_reg = SLOW_RESET;
            fast_reg = FAST_RESET;
            clear_measurement();
            pending_ratios.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_ratios.size() == 0) begin
                    $error("result word with none expected: ratio %0d, boom_silent %0d",
                           i_out_data.ratio, i_out_data.boom_silent);
                    fails++;
                end else begin
                    want = pending_ratios.pop_front();
                    if (i_out_data.ratio !== want.ratio) begin
                        $error("ratio: expected %0d, actual %0d", want.ratio, i_out_data.ratio);
                        fails++;
                    end
                    if (i_out_data.boom_silent !== want.boom_silent) begin
                        $error("boom_silent: expected %0d, actual %0d",
                               want.boom_silent, i_out_data.boom_silent);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                measure_sample(i_in_data, emits, want);
                if (emits)
                    pending_ratios.push_back(want);
            end
            if (i_psel && i_penable && i_pready) begin
                reg_sel = t_ber_reg'(i_paddr[APB_ADDR_BITS-1:2]);
                case (reg_sel)
                    REG_WINDOW: held = window_reg;
                    REG_SLOW:   held = slow_reg;
                    default:    held = fast_reg;
                endcase
                if (i_pwrite) begin
                    case (reg_sel)
                        REG_WINDOW: window_reg = i_pwdata[WIN_BITS-1:0];
                        REG_SLOW:   slow_reg = i_pwdata[COEF_BITS-1:0];
                        REG_FAST:   fast_reg = i_pwdata[COEF_BITS-1:0];
                        default: ;
                    endcase
                end else if (i_prdata[COEF_BITS-1:0] !== held) begin
                    $error("%s readback: expected %0d, actual %0d",
                           reg_sel.name(), held, i_prdata[COEF_BITS-1:0]);
                    fails++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= pending_ratios.size();
    end

endmodule

// ----- verif/band_energy_ratio_meter_test.sv -----
`timescale 1ns / 1ps
// Top of the band energy ratio meter testbench: clock, reset, sample and
// register stimulus, and the verdict. Depends on ber_pkg, the block and its checker.
module band_energy_ratio_meter_test;
    import ber_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 160;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                     i_clk;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_ber_in                  in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_ber_out                 out_data;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr     = '0;
    logic [APB_DATA_BITS-1:0] pwdata    = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    bit                       steady    = 1'b0;
    int                       fail_count;
    int                       pending;
    int                       cycles    = 0;

    band_energy_ratio_meter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    band_energy_ratio_meter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ready <= steady || ($urandom_range(99) >= 16);
    end

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic restart);
        while (!steady && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{sample: value, restart: restart};
        do @(posedge i_clk); while (!in_ready);
    endtask

    // psel stays high across back-to-back transfers; the caller lowers it.
    task automatic apb_access(input t_ber_reg sel, input logic write, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {sel, 2'b00};
        pwdata <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic set_registers(input logic [WIN_BITS-1:0] win,
                                 input logic [COEF_BITS-1:0] slow,
                                 input logic [COEF_BITS-1:0] fast);
        apb_access(REG_WINDOW, 1'b1, win);
        apb_access(REG_SLOW, 1'b1, slow);
        apb_access(REG_FAST, 1'b1, fast);
        apb_access(REG_WINDOW, 1'b0, '0);
        apb_access(REG_SLOW, 1'b0, '0);
        apb_access(REG_FAST, 1'b0, '0);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // A sample that closes no window may still be in the front end, hence the
    // extra cycles after the last expected word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [COEF_BITS-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return SLOW_RESET;
            3:       return FAST_RESET;
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    initial begin
        int                             total;
        int                             phase_len;
        logic signed [SAMPLE_BITS-1:0]  value;
        logic signed [SAMPLE_BITS-1:0]  level;
        logic                           restart_bit;
        logic [WIN_BITS-1:0]            win;
        logic [COEF_BITS-1:0]           slow;
        logic [COEF_BITS-1:0]           fast;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One word per sample; silence first, then both extremes of the sample, then -1 and 1.
        set_registers(16'd1, SLOW_RESET, FAST_RESET);
        push_sample('0, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_BITS'(-1), 1'b0);
        push_sample(SAMPLE_BITS'(1), 1'b0);
        drain();

        // A zero slow coefficient holds the boom filter, so every word is silent
        // even though the thump energy is not zero.
        set_registers(16'd1, '0, '1);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample('0, 1'b0);
        drain();

        // A window length of zero behaves as one.
        set_registers('0, '1, '0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_BITS'(1), 1'b0);
        drain();

        // Shorten the window below the count already taken.
        set_registers(16'd3, 16'd1000, 16'd20000);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        drain();
        set_registers(16'd1, 16'd1000, 16'd20000);
        push_sample(SAMPLE_MAX, 1'b0);
        drain();

        // A barely moving boom filter drives the ratio into saturation.
        set_registers(16'd4, 16'd1, '1);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        drain();

        total = 0;
        level = '0;
        while (total < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       win = '0;
                1:       win = 16'd1;
                2:       win = '1;
                default: win = WIN_BITS'($urandom_range(40, 2));
            endcase
            slow = pick_coef();
            fast = pick_coef();
            set_registers(win, slow, fast);
            phase_len = $urandom_range(80, 10);
            for (int n = 0; n < phase_len; n++) begin
                steady <= (total >= 400 && total < 700);
                case ($urandom_range(7))
                    0, 1:    value = SAMPLE_BITS'($urandom);
                    2:       value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                    3, 4:    value = SAMPLE_BITS'($signed(10'($urandom)));
                    default: begin
                        // A slowly wandering signal, closer to real audio.
                        level = level + SAMPLE_BITS'($signed(16'($urandom)));
                        value = level;
                    end
                endcase
                restart_bit = (n == 0) ? ($urandom_range(2) == 0) : ($urandom_range(49) == 0);
                push_sample(value, restart_bit);
                total++;
            end
            drain();
        end

        if (pending != 0)
            $error("%0d expected result words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $error("cycle limit of %0d reached", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule
